// File: rtl/core/free_area_allocator_defines.svh
// Assertion macros shared by the checker.
`ifndef FREE_AREA_ALLOCATOR_DEFINES_SVH
`define FREE_AREA_ALLOCATOR_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define FAA_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error("%m: check failed");
// Next-cycle implication checked outside reset.
`define FAA_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error("%m: check failed");
`endif

// File: rtl/core/faa_pkg.sv
// ----------------------------------------------------------------------------
// faa_pkg
// Types and constants of the free area allocator.
// ----------------------------------------------------------------------------
package faa_pkg;
	localparam int OFF_W       = 40;
	localparam int LEN_W       = 24;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 40;
	localparam int DEF_SLOTS   = 64;
	localparam logic [LEN_W-1:0] MIN_AREA_RST = LEN_W'(16);

	localparam logic [CFG_IDX_W-1:0] REG_MIN_AREA = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_OFF = 1'b1;

	localparam logic ACT_ALLOC   = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;

	typedef struct packed {
		logic             action;
		logic [LEN_W-1:0] length_bytes;
		logic [OFF_W-1:0] area_offset;
	} req_t;

	typedef struct packed {
		logic [OFF_W-1:0] grant_offset;
		logic [LEN_W-1:0] grant_length;
		logic             at_end;
		logic             table_full;
	} res_t;

	function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
		input logic [LEN_W-1:0] b);
		logic [LEN_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[LEN_W] ? {LEN_W{1'b1}} : s[LEN_W-1:0];
	endfunction
endpackage

// File: rtl/core/free_area_allocator.sv
// ----------------------------------------------------------------------------
// free_area_allocator
// Free area table with allocate and release requests, kept in one RAM.
// ----------------------------------------------------------------------------
// A request reads each table entry it scans from the RAM, then compares it,
// and reads, then writes back, each entry shifted when an entry is inserted
// or removed. This order is set by the table RAM, which gives one read a
// cycle. busy rises in the cycle after acceptance. The worst case is an
// allocate that scans a full table and then removes its first entry. The
// result is shown on res with res_valid for one cycle, the cycle in which busy
// falls, and cannot be held off. A zero-length release strobes in the cycle
// after acceptance and never raises busy. No clearing pass: only entries below
// the fill count are ever read.
module free_area_allocator import faa_pkg::*; #(
	parameter int FREE_SLOTS = DEF_SLOTS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  req_t                  req,
	output logic                  res_valid,
	output res_t                  res,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	localparam int IW = $clog2(FREE_SLOTS);
	localparam int CW = $clog2(FREE_SLOTS + 1);
	localparam logic [CW-1:0] SLOTS_C = CW'(FREE_SLOTS);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_SCAN  = 9'b000000010,
		ST_CHK   = 9'b000000100,
		ST_BEST  = 9'b000001000,
		ST_NEXT  = 9'b000010000,
		ST_RMRD  = 9'b000100000,
		ST_RMWR  = 9'b001000000,
		ST_INRD  = 9'b010000000,
		ST_INWR  = 9'b100000000
	} state_t;

	state_t state_q;
	logic [OFF_W+LEN_W-1:0] mem [FREE_SLOTS];
	logic [OFF_W+LEN_W-1:0] rd_q;
	logic             re, we;
	logic [IW-1:0]    ra, wa;
	logic [OFF_W+LEN_W-1:0] wd;

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (re) rd_q <= mem[ra];
	end

	req_t             r_q;
	res_t             res_q;
	logic             rv_q;
	logic [CW-1:0]    cnt_q, i_q, k_q;
	logic             hb_q;
	logic [IW-1:0]    best_q;
	logic [LEN_W-1:0] blen_q;
	logic [OFF_W-1:0] boff_q;
	logic [LEN_W-1:0] min_q;
	logic [OFF_W-1:0] end_q;
	logic [OFF_W-1:0] ioff_q;
	logic [LEN_W-1:0] ilen_q;
	logic [OFF_W-1:0] moff_q;
	logic [LEN_W-1:0] mlen_q;
	logic [IW-1:0]    midx_q;

	wire [OFF_W-1:0] e_off = rd_q[OFF_W+LEN_W-1:LEN_W];
	wire [LEN_W-1:0] e_len = rd_q[LEN_W-1:0];
	wire [OFF_W:0]   e_end = {1'b0, e_off} + {{(OFF_W-LEN_W+1){1'b0}}, e_len};
	wire [OFF_W:0]   r_end = {1'b0, r_q.area_offset} +
		{{(OFF_W-LEN_W+1){1'b0}}, r_q.length_bytes};
	wire [LEN_W:0]   lim   = {1'b0, r_q.length_bytes} + {1'b0, min_q};
	wire [OFF_W:0]   m_end = {1'b0, moff_q} + {{(OFF_W-LEN_W+1){1'b0}}, mlen_q};
	wire [LEN_W-1:0] glen  = (r_q.length_bytes > min_q) ? r_q.length_bytes : min_q;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE) && !start;
	assign res_valid = rv_q;
	assign res       = res_q;

	always_comb begin
		re = 1'b0; ra = '0; we = 1'b0; wa = '0; wd = '0;
		case (state_q)
			ST_SCAN: begin
				re = (i_q < cnt_q); ra = i_q[IW-1:0];
				// split of the best fit at the end of an allocate scan
				if (i_q >= cnt_q && r_q.action == ACT_ALLOC && hb_q &&
						blen_q != r_q.length_bytes) begin
					we = 1'b1; wa = best_q;
					wd = {boff_q + {{(OFF_W-LEN_W){1'b0}}, r_q.length_bytes},
						blen_q - r_q.length_bytes};
				end
			end
			ST_CHK: begin
				if (r_q.action == ACT_RELEASE) begin
					if (e_end == {1'b0, r_q.area_offset}) begin
						we = 1'b1; wa = i_q[IW-1:0];
						wd = {e_off, sat_add(e_len, r_q.length_bytes)};
					end else if ({1'b0, e_off} == r_end) begin
						we = 1'b1; wa = i_q[IW-1:0];
						wd = {r_q.area_offset, sat_add(e_len, r_q.length_bytes)};
					end
				end
			end
			ST_BEST: begin re = 1'b1; ra = i_q[IW-1:0]; end
			ST_NEXT: begin
				if (m_end == {1'b0, e_off}) begin
					we = 1'b1; wa = midx_q; wd = {moff_q, sat_add(mlen_q, e_len)};
				end
			end
			ST_RMRD: begin re = 1'b1; ra = IW'(k_q + 1'b1); end
			ST_RMWR: begin we = 1'b1; wa = k_q[IW-1:0]; wd = rd_q; end
			ST_INRD: begin
				re = (k_q > i_q); ra = IW'(k_q - 1'b1);
				if (k_q == i_q) begin
					we = 1'b1; wa = i_q[IW-1:0]; wd = {ioff_q, ilen_q};
				end
			end
			ST_INWR: begin we = 1'b1; wa = k_q[IW-1:0]; wd = rd_q; end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rv_q    <= 1'b0;
			cnt_q   <= '0;
			min_q   <= MIN_AREA_RST;
			end_q   <= '0;
		end else begin
			rv_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MIN_AREA: min_q <= cfg_data[LEN_W-1:0];
					REG_BASE_OFF: end_q <= cfg_data[OFF_W-1:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: if (start) begin
					r_q   <= req;
					res_q <= '0;
					i_q   <= '0;
					hb_q  <= 1'b0;
					if (req.action == ACT_RELEASE && req.length_bytes == '0) rv_q <= 1'b1;
					else state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (i_q < cnt_q) state_q <= ST_CHK;
					else if (r_q.action == ACT_RELEASE) begin
						ioff_q <= r_q.area_offset; ilen_q <= r_q.length_bytes;
						if (cnt_q >= SLOTS_C) begin
							res_q.table_full <= 1'b1; rv_q <= 1'b1; state_q <= ST_IDLE;
						end else begin
							k_q <= cnt_q; i_q <= cnt_q; state_q <= ST_INRD;
						end
					end else if (hb_q) begin
						res_q.grant_offset <= boff_q;
						res_q.grant_length <= r_q.length_bytes;
						if (blen_q == r_q.length_bytes) begin
							k_q <= CW'(best_q); state_q <= ST_RMRD;
							if (CW'(best_q) + 1'b1 >= cnt_q) begin
								cnt_q <= cnt_q - 1'b1; rv_q <= 1'b1; state_q <= ST_IDLE;
							end
						end else begin
							rv_q <= 1'b1; state_q <= ST_IDLE;
						end
					end else begin
						res_q.grant_offset <= end_q;
						res_q.grant_length <= glen;
						res_q.at_end       <= 1'b1;
						end_q <= end_q + {{(OFF_W-LEN_W){1'b0}}, glen};
						rv_q <= 1'b1; state_q <= ST_IDLE;
					end
				end
				ST_CHK: begin
					state_q <= ST_SCAN;
					i_q <= i_q + 1'b1;
					if (r_q.action == ACT_ALLOC) begin
						if (e_len >= r_q.length_bytes) begin
							if ({1'b0, e_len} < lim) begin
								res_q.grant_offset <= e_off;
								res_q.grant_length <= e_len;
								k_q <= i_q;
								if (i_q + 1'b1 >= cnt_q) begin
									cnt_q <= cnt_q - 1'b1; rv_q <= 1'b1; state_q <= ST_IDLE;
								end else state_q <= ST_RMRD;
							end else if (!hb_q || e_len < blen_q) begin
								hb_q <= 1'b1; best_q <= i_q[IW-1:0];
								blen_q <= e_len; boff_q <= e_off;
							end
						end
					end else begin
						if (e_end == {1'b0, r_q.area_offset}) begin
							moff_q <= e_off;
							mlen_q <= sat_add(e_len, r_q.length_bytes);
							midx_q <= i_q[IW-1:0];
							if (i_q + 1'b1 < cnt_q) state_q <= ST_BEST;
							else begin rv_q <= 1'b1; state_q <= ST_IDLE; end
						end else if ({1'b0, e_off} == r_end) begin
							rv_q <= 1'b1; state_q <= ST_IDLE;
						end else if (e_off > r_q.area_offset) begin
							ioff_q <= r_q.area_offset; ilen_q <= r_q.length_bytes;
							if (cnt_q >= SLOTS_C) begin
								res_q.table_full <= 1'b1; rv_q <= 1'b1; state_q <= ST_IDLE;
							end else begin
								k_q <= cnt_q; state_q <= ST_INRD;
							end
							i_q <= i_q;
						end
					end
				end
				ST_BEST: state_q <= ST_NEXT; // read of following entry in flight
				ST_NEXT: begin
					if (m_end == {1'b0, e_off}) begin
						k_q <= i_q;
						if (i_q + 1'b1 >= cnt_q) begin
							cnt_q <= cnt_q - 1'b1; rv_q <= 1'b1; state_q <= ST_IDLE;
						end else state_q <= ST_RMRD;
					end else begin
						rv_q <= 1'b1; state_q <= ST_IDLE;
					end
				end
				ST_RMRD: state_q <= ST_RMWR;
				ST_RMWR: begin
					k_q <= k_q + 1'b1;
					if (k_q + 2'd2 >= cnt_q) begin
						cnt_q <= cnt_q - 1'b1; rv_q <= 1'b1; state_q <= ST_IDLE;
					end else state_q <= ST_RMRD;
				end
				ST_INRD: begin
					if (k_q == i_q) begin
						cnt_q <= cnt_q + 1'b1; rv_q <= 1'b1; state_q <= ST_IDLE;
					end else state_q <= ST_INWR;
				end
				ST_INWR: begin k_q <= k_q - 1'b1; state_q <= ST_INRD; end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// File: rtl/core/faa_checker.sv
// ----------------------------------------------------------------------------
// faa_checker
// Port-level checks of the free area allocator.
// ----------------------------------------------------------------------------
`include "free_area_allocator_defines.svh"
module faa_checker import faa_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic res_valid,
	input res_t res,
	input logic cfg_valid,
	input logic cfg_ready
);
	`FAA_ASSERT_NXT(a_start_busy, clk, arst_n, start && !busy, busy || res_valid)
	`FAA_ASSERT_IMP(a_res_end, clk, arst_n, res_valid, !busy)
	`FAA_ASSERT_IMP(a_cfg_idle, clk, arst_n, cfg_valid && cfg_ready, !busy)
	`FAA_ASSERT_IMP(a_flag_excl, clk, arst_n, res_valid && res.table_full,
		!res.at_end && res.grant_length == '0)
	// busy only ever falls with a result
	`FAA_ASSERT_NXT(a_busy_done, clk, arst_n, busy, busy || res_valid)
endmodule

bind free_area_allocator faa_checker u_faa_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.res_valid(res_valid), .res(res), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
);
